### rtl/rmq_pkg.sv
// types and constants shared by the rotation matrix to quaternion pipeline
package rmq_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int GUARD_BITS = 11;
  localparam int IN_W       = 16;
  localparam int EXT_W      = 19;
  localparam int MAG_W      = 17;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int N_W        = SQ_W + 2;
  localparam int X_W        = N_W + 2 * GUARD_BITS;
  localparam int ROOT_W     = X_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 3;
  localparam int Q_W        = 16;
  localparam int SCALE_SH   = FRAC_BITS + GUARD_BITS;
  localparam int DIV_D_W    = MAG_W + SCALE_SH + 1;
  localparam int DV_REM_W   = ROOT_W + 1;

  typedef struct packed {
    logic signed [IN_W-1:0] rot_00;
    logic signed [IN_W-1:0] rot_01;
    logic signed [IN_W-1:0] rot_02;
    logic signed [IN_W-1:0] rot_10;
    logic signed [IN_W-1:0] rot_11;
    logic signed [IN_W-1:0] rot_12;
    logic signed [IN_W-1:0] rot_20;
    logic signed [IN_W-1:0] rot_21;
    logic signed [IN_W-1:0] rot_22;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] quat_w;
    logic signed [Q_W-1:0] quat_x;
    logic signed [Q_W-1:0] quat_y;
    logic signed [Q_W-1:0] quat_z;
    logic                  invalid;
  } out_t;

  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            neg;
    logic                  invalid;
  } comp_t;

endpackage

### rtl/rmq_prep.sv
// branch select, component magnitudes, squares and squared norm (three stages)
module rmq_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rmq_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rmq_pkg::comp_t             out_comp_o,
  output logic [rmq_pkg::N_W-1:0]    out_n_o
);
  import rmq_pkg::*;

  logic [2:0] vld_q;
  logic en_a, en_b, en_c;

  comp_t a_d, a_q;
  comp_t b_q;
  logic [3:0][SQ_W-1:0] sq_d, sq_q;
  comp_t c_d, c_q;
  logic [N_W-1:0] n_d, n_q;

  logic signed [EXT_W-1:0] r [9];
  logic signed [EXT_W-1:0] v [4];
  logic signed [EXT_W-1:0] trace, av, one, absv;

  assign en_c = !vld_q[2] || out_ready_i;
  assign en_b = !vld_q[1] || en_c;
  assign en_a = !vld_q[0] || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    r[0] = EXT_W'(in_data_i.rot_00);
    r[1] = EXT_W'(in_data_i.rot_01);
    r[2] = EXT_W'(in_data_i.rot_02);
    r[3] = EXT_W'(in_data_i.rot_10);
    r[4] = EXT_W'(in_data_i.rot_11);
    r[5] = EXT_W'(in_data_i.rot_12);
    r[6] = EXT_W'(in_data_i.rot_20);
    r[7] = EXT_W'(in_data_i.rot_21);
    r[8] = EXT_W'(in_data_i.rot_22);
    one = EXT_W'(1) <<< FRAC_BITS;
    trace = r[0] + r[4] + r[8];
    av = one;
    if (trace > 0) begin
      v[0] = trace + one;
      v[1] = r[7] - r[5];
      v[2] = r[2] - r[6];
      v[3] = r[3] - r[1];
    end else if (r[0] > r[4] && r[0] > r[8]) begin
      av = one + r[0] - r[4] - r[8];
      v[0] = r[7] - r[5];
      v[1] = av;
      v[2] = r[1] + r[3];
      v[3] = r[2] + r[6];
    end else if (r[4] > r[8]) begin
      av = one + r[4] - r[0] - r[8];
      v[0] = r[2] - r[6];
      v[1] = r[1] + r[3];
      v[2] = av;
      v[3] = r[5] + r[7];
    end else begin
      av = one + r[8] - r[0] - r[4];
      v[0] = r[3] - r[1];
      v[1] = r[2] + r[6];
      v[2] = r[5] + r[7];
      v[3] = av;
    end
    absv = '0;
    for (int i = 0; i < 4; i++) begin
      absv = v[i][EXT_W-1] ? -v[i] : v[i];
      a_d.mag[i] = absv[MAG_W-1:0];
      a_d.neg[i] = v[i][EXT_W-1];
    end
    a_d.invalid = (av <= 0);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_d[i] = a_q.mag[i] * a_q.mag[i];
    end
  end

  always_comb begin
    n_d = N_W'(sq_q[0]) + N_W'(sq_q[1]) + N_W'(sq_q[2]) + N_W'(sq_q[3]);
    c_d = b_q;
    c_d.invalid = b_q.invalid || (n_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_a) vld_q[0] <= in_valid_i;
      if (en_b) vld_q[1] <= vld_q[0];
      if (en_c) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) a_q <= a_d;
    if (en_b) begin
      b_q  <= a_q;
      sq_q <= sq_d;
    end
    if (en_c) begin
      c_q <= c_d;
      n_q <= n_d;
    end
  end

  assign out_valid_o = vld_q[2];
  assign out_comp_o  = c_q;
  assign out_n_o     = n_q;

endmodule

### rtl/rmq_sqrt.sv
// pipelined digit-by-digit integer square root of the scaled squared norm
module rmq_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rmq_pkg::comp_t              in_comp_i,
  input  logic [rmq_pkg::N_W-1:0]     in_n_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rmq_pkg::comp_t              out_comp_o,
  output logic [rmq_pkg::ROOT_W-1:0]  out_root_o
);
  import rmq_pkg::*;

  localparam int SQ_STEPS  = 4;
  localparam int SQ_STAGES = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;

  typedef struct packed {
    logic [X_W-1:0]      x;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    comp_t               comp;
  } sq_st_t;

  sq_st_t st_in [SQ_STAGES];
  sq_st_t st_d  [SQ_STAGES];
  sq_st_t st_q  [SQ_STAGES];
  logic [SQ_STAGES-1:0] vin;
  logic [SQ_STAGES-1:0] vld_q;
  logic [SQ_STAGES:0]   rdy;

  assign rdy[SQ_STAGES] = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    assign rdy[s] = !vld_q[s] || rdy[s+1];

    if (s == 0) begin : g_first
      assign vin[s]         = in_valid_i;
      assign st_in[s].x     = {in_n_i, (2 * GUARD_BITS)'(0)};
      assign st_in[s].rem   = '0;
      assign st_in[s].root  = '0;
      assign st_in[s].comp  = in_comp_i;
    end else begin : g_next
      assign vin[s]   = vld_q[s-1];
      assign st_in[s] = st_q[s-1];
    end

    always_comb begin
      sq_st_t cur;
      logic [SQ_REM_W-1:0] t;
      logic [SQ_REM_W-1:0] trial;
      cur = st_in[s];
      t = '0;
      trial = '0;
      for (int j = 0; j < SQ_STEPS; j++) begin
        if (s * SQ_STEPS + j < ROOT_W) begin
          t = {cur.rem[SQ_REM_W-3:0], cur.x[X_W-1 -: 2]};
          trial = {1'b0, cur.root, 2'b01};
          cur.x = cur.x << 2;
          if (t >= trial) begin
            cur.rem  = t - trial;
            cur.root = {cur.root[ROOT_W-2:0], 1'b1};
          end else begin
            cur.rem  = t;
            cur.root = {cur.root[ROOT_W-2:0], 1'b0};
          end
        end
      end
      st_d[s] = cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= vin[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) st_q[s] <= st_d[s];
    end
  end

  assign out_valid_o = vld_q[SQ_STAGES-1];
  assign out_comp_o  = st_q[SQ_STAGES-1].comp;
  assign out_root_o  = st_q[SQ_STAGES-1].root;

endmodule

### rtl/rmq_div.sv
// pipelined rounded division of the four magnitudes by the norm, output format
module rmq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rmq_pkg::comp_t              in_comp_i,
  input  logic [rmq_pkg::ROOT_W-1:0]  in_root_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rmq_pkg::out_t               out_data_o
);
  import rmq_pkg::*;

  localparam int DV_STEPS  = 4;
  localparam int DV_STAGES = (Q_W + DV_STEPS - 1) / DV_STEPS;

  typedef struct packed {
    logic [3:0][DV_REM_W-1:0] rem;
    logic [3:0][Q_W-1:0]      d;
    logic [ROOT_W-1:0]        root;
    comp_t                    comp;
  } dv_st_t;

  dv_st_t st_in [DV_STAGES];
  dv_st_t st_d  [DV_STAGES];
  dv_st_t st_q  [DV_STAGES];
  logic [DV_STAGES-1:0] vin;
  logic [DV_STAGES-1:0] vld_q;
  logic [DV_STAGES:0]   rdy;

  dv_st_t first_c;
  logic [3:0][DIV_D_W-1:0] dvd;

  out_t out_d, out_q;
  logic out_vld_q;

  assign rdy[DV_STAGES] = !out_vld_q || out_ready_i;
  assign in_ready_o = rdy[0];

  always_comb begin
    first_c.root = in_root_i;
    first_c.comp = in_comp_i;
    for (int i = 0; i < 4; i++) begin
      dvd[i] = DIV_D_W'({in_comp_i.mag[i], SCALE_SH'(0)})
             + DIV_D_W'(in_root_i[ROOT_W-1:1]);
      first_c.rem[i] = DV_REM_W'(dvd[i][DIV_D_W-1:Q_W]);
      first_c.d[i]   = dvd[i][Q_W-1:0];
    end
  end

  for (genvar s = 0; s < DV_STAGES; s++) begin : g_stage
    assign rdy[s] = !vld_q[s] || rdy[s+1];

    if (s == 0) begin : g_first
      assign vin[s]   = in_valid_i;
      assign st_in[s] = first_c;
    end else begin : g_next
      assign vin[s]   = vld_q[s-1];
      assign st_in[s] = st_q[s-1];
    end

    always_comb begin
      dv_st_t cur;
      logic [DV_REM_W-1:0] t;
      cur = st_in[s];
      t = '0;
      for (int j = 0; j < DV_STEPS; j++) begin
        if (s * DV_STEPS + j < Q_W) begin
          for (int i = 0; i < 4; i++) begin
            t = {cur.rem[i][DV_REM_W-2:0], cur.d[i][Q_W-1]};
            cur.d[i] = {cur.d[i][Q_W-2:0], 1'b0};
            if (t >= {1'b0, cur.root}) begin
              t = t - {1'b0, cur.root};
              cur.d[i][0] = 1'b1;
            end
            cur.rem[i] = t;
          end
        end
      end
      st_d[s] = cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= vin[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) st_q[s] <= st_d[s];
    end
  end

  always_comb begin
    logic [3:0][Q_W-1:0] qv;
    logic [Q_W-1:0] qs;
    qs = '0;
    for (int i = 0; i < 4; i++) begin
      qs = st_q[DV_STAGES-1].d[i][Q_W-1] ? {1'b0, {(Q_W-1){1'b1}}}
                                         : st_q[DV_STAGES-1].d[i];
      if (st_q[DV_STAGES-1].comp.invalid) begin
        qv[i] = '0;
      end else if (st_q[DV_STAGES-1].comp.neg[i]) begin
        qv[i] = -qs;
      end else begin
        qv[i] = qs;
      end
    end
    out_d.quat_w  = qv[0];
    out_d.quat_x  = qv[1];
    out_d.quat_y  = qv[2];
    out_d.quat_z  = qv[3];
    out_d.invalid = st_q[DV_STAGES-1].comp.invalid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy[DV_STAGES]) begin
      out_vld_q <= vld_q[DV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[DV_STAGES]) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### rtl/rotation_matrix_to_quaternion.sv
// top level: rotation matrix to unit quaternion pipeline
// throughput one item per cycle while out_ready_i applies no backpressure:
// 3 prep stages, 8 square root stages (up to 4 root bits each), 4 divide
// stages (4 quotient bits each), 1 format stage
// each stage holds under backpressure, so nothing is lost or repeated
// rst_ni clears all valid bits; payload registers are not reset
module rotation_matrix_to_quaternion (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rmq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rmq_pkg::out_t out_data_o
);
  import rmq_pkg::*;

  logic           p_valid, p_ready;
  comp_t          p_comp;
  logic [N_W-1:0] p_n;

  logic              s_valid, s_ready;
  comp_t             s_comp;
  logic [ROOT_W-1:0] s_root;

  rmq_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .out_comp_o  (p_comp),
    .out_n_o     (p_n)
  );

  rmq_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .in_comp_i   (p_comp),
    .in_n_i      (p_n),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .out_comp_o  (s_comp),
    .out_root_o  (s_root)
  );

  rmq_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid),
    .in_ready_o  (s_ready),
    .in_comp_i   (s_comp),
    .in_root_i   (s_root),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/rotation_matrix_to_quaternion_tb.sv
// testbench for the rotation matrix to quaternion pipeline with a scoreboard
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int LATENCY   = 16;
  localparam int MAX_CYCLE = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  out_t quat_q[$];
  int   fail_cnt;
  int   cycle_cnt;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_cycles;

  rotation_matrix_to_quaternion dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic out_t matrix_to_quat(in_t m);
    longint r[9];
    longint v[4];
    longint unsigned mag[4];
    bit neg[4];
    longint one;
    longint tr;
    longint a;
    longint unsigned maxm;
    longint unsigned n;
    longint unsigned root;
    longint unsigned q;
    logic [15:0] comp[4];
    out_t o;
    one = 64'sd1 <<< FRAC_BITS;
    a = 1;
    r[0] = m.rot_00; r[1] = m.rot_01; r[2] = m.rot_02;
    r[3] = m.rot_10; r[4] = m.rot_11; r[5] = m.rot_12;
    r[6] = m.rot_20; r[7] = m.rot_21; r[8] = m.rot_22;
    tr = r[0] + r[4] + r[8];
    if (tr > 0) begin
      v[0] = tr + one; v[1] = r[7] - r[5]; v[2] = r[2] - r[6]; v[3] = r[3] - r[1];
    end else if (r[0] > r[4] && r[0] > r[8]) begin
      a = one + r[0] - r[4] - r[8];
      v[0] = r[7] - r[5]; v[1] = a; v[2] = r[1] + r[3]; v[3] = r[2] + r[6];
    end else if (r[4] > r[8]) begin
      a = one + r[4] - r[0] - r[8];
      v[0] = r[2] - r[6]; v[1] = r[1] + r[3]; v[2] = a; v[3] = r[5] + r[7];
    end else begin
      a = one + r[8] - r[0] - r[4];
      v[0] = r[3] - r[1]; v[1] = r[2] + r[6]; v[2] = r[5] + r[7]; v[3] = a;
    end
    o = '0;
    if (a <= 0) begin
      o.invalid = 1'b1;
      return o;
    end
    maxm = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > maxm) maxm = mag[i];
    end
    while (maxm >= (64'd1 << 20)) begin
      for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
      maxm = maxm >> 1;
    end
    n = 0;
    for (int i = 0; i < 4; i++) n = n + mag[i] * mag[i];
    root = int_sqrt(n << (2 * GUARD_BITS));
    if (root == 0) begin
      o.invalid = 1'b1;
      return o;
    end
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << (FRAC_BITS + GUARD_BITS)) + (root >> 1)) / root;
      if (q > 32767) q = 32767;
      comp[i] = neg[i] ? 16'(17'h10000 - q) : 16'(q);
    end
    o.quat_w = comp[0];
    o.quat_x = comp[1];
    o.quat_y = comp[2];
    o.quat_z = comp[3];
    return o;
  endfunction

  task automatic send_matrix(in_t m);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    quat_q.push_back(matrix_to_quat(m));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'h4000;
      2: return 16'hc000;
      3: return 16'h0000;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic in_t rand_rotation();
    real qw, qx, qy, qz, nr;
    real e[9];
    in_t m;
    qw = $urandom_range(2000) / 1000.0 - 1.0;
    qx = $urandom_range(2000) / 1000.0 - 1.0;
    qy = $urandom_range(2000) / 1000.0 - 1.0;
    qz = $urandom_range(2000) / 1000.0 - 1.0;
    nr = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    if (nr < 0.01) begin
      qw = 1.0; nr = 1.0;
    end
    qw = qw / nr; qx = qx / nr; qy = qy / nr; qz = qz / nr;
    e[0] = 1 - 2 * (qy * qy + qz * qz);
    e[1] = 2 * (qx * qy - qz * qw);
    e[2] = 2 * (qx * qz + qy * qw);
    e[3] = 2 * (qx * qy + qz * qw);
    e[4] = 1 - 2 * (qx * qx + qz * qz);
    e[5] = 2 * (qy * qz - qx * qw);
    e[6] = 2 * (qx * qz - qy * qw);
    e[7] = 2 * (qy * qz + qx * qw);
    e[8] = 1 - 2 * (qx * qx + qy * qy);
    m.rot_00 = 16'($rtoi(e[0] * 16384.0)); m.rot_01 = 16'($rtoi(e[1] * 16384.0));
    m.rot_02 = 16'($rtoi(e[2] * 16384.0)); m.rot_10 = 16'($rtoi(e[3] * 16384.0));
    m.rot_11 = 16'($rtoi(e[4] * 16384.0)); m.rot_12 = 16'($rtoi(e[5] * 16384.0));
    m.rot_20 = 16'($rtoi(e[6] * 16384.0)); m.rot_21 = 16'($rtoi(e[7] * 16384.0));
    m.rot_22 = 16'($rtoi(e[8] * 16384.0));
    return m;
  endfunction

  function automatic in_t rand_noise();
    in_t m;
    m.rot_00 = rand_entry(); m.rot_01 = rand_entry(); m.rot_02 = rand_entry();
    m.rot_10 = rand_entry(); m.rot_11 = rand_entry(); m.rot_12 = rand_entry();
    m.rot_20 = rand_entry(); m.rot_21 = rand_entry(); m.rot_22 = rand_entry();
    return m;
  endfunction

  function automatic in_t diag(int d0, int d1, int d2);
    in_t m;
    m = '0;
    m.rot_00 = 16'(d0);
    m.rot_11 = 16'(d1);
    m.rot_22 = 16'(d2);
    return m;
  endfunction

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic test_directed();
    in_t m;
    send_matrix(diag(16384, 16384, 16384));
    send_matrix(diag(16384, -16384, -16384));
    send_matrix(diag(-16384, 16384, -16384));
    send_matrix(diag(-16384, -16384, 16384));
    send_matrix(diag(0, 0, 0));
    send_matrix(diag(-16384, -16384, -16384));
    send_matrix(diag(-32768, -32768, -32768));
    send_matrix(diag(32767, 32767, 32767));
    send_matrix(diag(32767, -32768, -32768));
    send_matrix(diag(-32768, 32767, -32768));
    send_matrix(diag(-32768, -32768, 32767));
    send_matrix(diag(-8192, -8192, -8192));
    send_matrix(diag(-16384, 0, 0));
    m = '0;
    m.rot_01 = 16'sh7fff; m.rot_10 = 16'sh8000; m.rot_22 = 16'sh8000;
    send_matrix(m);
    m = {9{16'hffff}};
    send_matrix(m);
    m = {9{16'h8000}};
    send_matrix(m);
    m = {9{16'h7fff}};
    send_matrix(m);
    m = {9{16'h5555}};
    send_matrix(m);
    m = {9{16'haaaa}};
    send_matrix(m);
    wait_drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) send_matrix(rand_rotation());
      else send_matrix(rand_noise());
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) send_matrix(rand_rotation());
    wait_drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    fail_cnt       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500, 0, 0);
    test_random(500, 60, 0);
    test_random(500, 0, 60);
    test_random(500, 38, 38);
    test_backpressure();
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ready_i <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_t exp_quat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quat_q.size() == 0) begin
        $error("unexpected quaternion item %h", out_data_o);
        fail_cnt++;
      end else begin
        exp_quat = quat_q.pop_front();
        if (out_data_o.quat_w !== exp_quat.quat_w) begin
          $error("quat_w expected %h actual %h", exp_quat.quat_w, out_data_o.quat_w);
          fail_cnt++;
        end
        if (out_data_o.quat_x !== exp_quat.quat_x) begin
          $error("quat_x expected %h actual %h", exp_quat.quat_x, out_data_o.quat_x);
          fail_cnt++;
        end
        if (out_data_o.quat_y !== exp_quat.quat_y) begin
          $error("quat_y expected %h actual %h", exp_quat.quat_y, out_data_o.quat_y);
          fail_cnt++;
        end
        if (out_data_o.quat_z !== exp_quat.quat_z) begin
          $error("quat_z expected %h actual %h", exp_quat.quat_z, out_data_o.quat_z);
          fail_cnt++;
        end
        if (out_data_o.invalid !== exp_quat.invalid) begin
          $error("invalid expected %b actual %b", exp_quat.invalid, out_data_o.invalid);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > MAX_CYCLE) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
